>>> sv/object_constant_velocity_predictor_macros.svh
// assertion helpers for the predictor checker
`ifndef OBJECT_CONSTANT_VELOCITY_PREDICTOR_MACROS_SVH
`define OBJECT_CONSTANT_VELOCITY_PREDICTOR_MACROS_SVH

// same-cycle implication
`define OCVP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OCVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ocvp_pkg.sv
package ocvp_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef struct packed {
        logic       rd;
        logic       check;
        logic       mul_a;
        logic       mul_b;
        logic       div_s;
        logic       div_o;
        logic       save_s;
        logic       save_o;
        logic       emit;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic keep;
        logic few;
        logic same;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> sv/ocvp_div.sv
module ocvp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [63:0] o_quotient,
    output logic        o_done
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        bit_q;

    // one quotient bit a cycle, restoring
    always_comb begin
        sh    = {r_rem, r_quo[63]};
        diff  = sh - {1'b0, r_div};
        bit_q = (sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= bit_q ? diff[31:0] : sh[31:0];
            r_quo <= {r_quo[62:0], bit_q};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

>>> sv/ocvp_ctrl.sv
module ocvp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ocvp_pkg::t_stat  i_stat,
    output ocvp_pkg::t_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_READ  = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_MULA  = 10'b00_0000_1000,
        S_MULB  = 10'b00_0001_0000,
        S_DIVS  = 10'b00_0010_0000,
        S_WAITS = 10'b00_0100_0000,
        S_DIVO  = 10'b00_1000_0000,
        S_WAITO = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                n_axis = '0;
                priority if (i_stat.ignore || !i_stat.keep) n_state = S_IDLE;
                else if (i_stat.few || i_stat.same)         n_state = S_EMIT;
                else                                        n_state = S_MULA;
            end
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_DIVS;
            S_DIVS:  n_state = S_WAITS;
            S_WAITS: if (i_stat.div_done) n_state = S_DIVO;
            S_DIVO:  n_state = S_WAITO;
            S_WAITO: begin
                if (i_stat.div_done) begin
                    if (r_axis == ocvp_pkg::LAST_AXIS) begin
                        n_state = S_EMIT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_MULA;
                    end
                end
            end
            S_EMIT:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.rd     = (r_state == S_READ);
    assign o_cmd.check  = (r_state == S_CHECK);
    assign o_cmd.mul_a  = (r_state == S_MULA);
    assign o_cmd.mul_b  = (r_state == S_MULB);
    assign o_cmd.div_s  = (r_state == S_DIVS);
    assign o_cmd.div_o  = (r_state == S_DIVO);
    assign o_cmd.save_s = (r_state == S_WAITS) && i_stat.div_done;
    assign o_cmd.save_o = (r_state == S_WAITO) && i_stat.div_done;
    assign o_cmd.emit   = (r_state == S_EMIT) && i_stat.out_free;
    assign o_cmd.axis   = r_axis;

endmodule

>>> sv/ocvp_dp.sv
module ocvp_dp #(
    parameter int OBJECTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_accept,
    input  logic [2:0]          i_object_id,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [31:0]         i_sample_time,
    input  ocvp_pkg::t_cmd      i_cmd,
    output ocvp_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_object_num,
    output logic [1:0]          o_status,
    output logic [31:0]         o_time_first,
    output logic [31:0]         o_time_last,
    output logic signed [47:0]  o_slope_x,
    output logic signed [47:0]  o_slope_y,
    output logic signed [47:0]  o_slope_z,
    output logic signed [63:0]  o_offset_x,
    output logic signed [63:0]  o_offset_y,
    output logic signed [63:0]  o_offset_z
);

    localparam int IW = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

    logic [7:0]   r_skip_period;
    logic [7:0]   r_skip [OBJECTS];
    logic [1:0]   r_count [OBJECTS];
    logic [127:0] r_mem [OBJECTS];
    logic [127:0] r_rd;

    logic [2:0]   r_id;
    logic [31:0]  r_ix, r_iy, r_iz, r_it;
    logic [31:0]  r_ox, r_oy, r_oz, r_ot;
    logic [31:0]  r_nx, r_ny, r_nz, r_nt;
    logic         r_dneg;
    logic [31:0]  r_dmag;
    logic [1:0]   r_status;
    logic signed [63:0] r_pa, r_pb;
    logic         r_neg;
    logic [47:0]  r_slope [3];
    logic [63:0]  r_off [3];

    logic                r_out_valid;
    logic [2:0]          r_o_id;
    logic [1:0]          r_o_status;
    logic [31:0]         r_o_tf, r_o_tl;
    logic [47:0]         r_o_slope [3];
    logic [63:0]         r_o_off [3];

    logic [IW-1:0] idx;
    logic          in_range;
    logic [7:0]    cnt_inc;
    logic          keep;
    logic          few;
    logic          same;
    logic [31:0]   prev_t;
    logic [31:0]   a_sel, b_sel;
    logic signed [64:0] prod;
    logic signed [32:0] num;
    logic [32:0]   smag;
    logic [63:0]   omag;
    logic          oneg;
    logic          div_start;
    logic [63:0]   div_dividend;
    logic [63:0]   quo;
    logic          div_done;
    logic [63:0]   off_sat;
    logic          out_free;

    assign idx      = IW'(r_id);
    assign in_range = (32'(r_id) < OBJECTS);
    assign cnt_inc  = (r_skip[idx] == 8'hFF) ? 8'hFF : r_skip[idx] + 8'd1;
    assign keep     = (cnt_inc >= r_skip_period);
    assign few      = (r_count[idx] == 2'd0);
    assign prev_t   = r_rd[127:96];
    assign same     = (prev_t == r_it);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.ignore   = !in_range;
        o_stat.keep     = keep;
        o_stat.few      = few;
        o_stat.same     = same;
        o_stat.div_done = div_done;
        o_stat.out_free = out_free;
    end

    always_comb begin
        unique case (i_cmd.axis)
            2'd0:    begin a_sel = r_ox; b_sel = r_nx; end
            2'd1:    begin a_sel = r_oy; b_sel = r_ny; end
            default: begin a_sel = r_oz; b_sel = r_nz; end
        endcase
    end

    // one shared multiplier: older value by newer time, then newer value by older time
    always_comb begin
        if (i_cmd.mul_a) prod = $signed(a_sel) * $signed({1'b0, r_nt});
        else             prod = $signed(b_sel) * $signed({1'b0, r_ot});
    end

    always_comb begin
        num  = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
        smag = num[32] ? 33'(-num) : 33'(num);
        if (r_pa >= r_pb) begin
            oneg = 1'b0;
            omag = r_pa - r_pb;
        end else begin
            oneg = 1'b1;
            omag = r_pb - r_pa;
        end
        div_start    = i_cmd.div_s || i_cmd.div_o;
        div_dividend = i_cmd.div_o ? omag : {31'd0, smag};
    end

    ocvp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_dmag),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    always_comb begin
        if (r_neg) begin
            off_sat = (quo > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -quo;
        end else begin
            off_sat = quo[63] ? 64'h7FFF_FFFF_FFFF_FFFF : quo;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_period <= 8'd1;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < OBJECTS; i++) begin
                r_skip[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) r_skip_period <= i_cfg_wr_data;
            if (i_cmd.check && in_range) begin
                r_skip[idx] <= keep ? 8'd0 : cnt_inc;
                if (keep && r_count[idx] != 2'd2) r_count[idx] <= r_count[idx] + 2'd1;
            end
            if (i_cmd.emit)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // sample store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= r_mem[idx];
        if (i_cmd.check && in_range && keep) r_mem[idx] <= {r_it, r_iz, r_iy, r_ix};
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_id <= i_object_id;
            r_ix <= i_pos_x;
            r_iy <= i_pos_y;
            r_iz <= i_pos_z;
            r_it <= i_sample_time;
        end
        if (i_cmd.check) begin
            // an object with nothing stored yet reads as zero
            r_ox <= few ? 32'd0 : r_rd[31:0];
            r_oy <= few ? 32'd0 : r_rd[63:32];
            r_oz <= few ? 32'd0 : r_rd[95:64];
            r_ot <= few ? 32'd0 : prev_t;
            r_nx <= r_ix;
            r_ny <= r_iy;
            r_nz <= r_iz;
            r_nt <= r_it;
            r_dneg <= (r_it < prev_t);
            r_dmag <= (r_it < prev_t) ? prev_t - r_it : r_it - prev_t;
            priority if (few) r_status <= ocvp_pkg::ST_FEW;
            else if (same)    r_status <= ocvp_pkg::ST_SAME;
            else              r_status <= ocvp_pkg::ST_OK;
            for (int i = 0; i < 3; i++) begin
                r_slope[i] <= '0;
                r_off[i]   <= '0;
            end
        end
        if (i_cmd.mul_a) r_pa <= prod[63:0];
        if (i_cmd.mul_b) r_pb <= prod[63:0];
        if (i_cmd.div_s) r_neg <= num[32] ^ r_dneg;
        if (i_cmd.div_o) r_neg <= oneg ^ r_dneg;
        if (i_cmd.save_s) r_slope[i_cmd.axis] <= r_neg ? -quo[47:0] : quo[47:0];
        if (i_cmd.save_o) r_off[i_cmd.axis] <= off_sat;
        if (i_cmd.emit) begin
            r_o_id     <= r_id;
            r_o_status <= r_status;
            r_o_tf     <= r_ot;
            r_o_tl     <= r_nt;
            r_o_slope  <= r_slope;
            r_o_off    <= r_off;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_object_num = r_o_id;
    assign o_status     = r_o_status;
    assign o_time_first = r_o_tf;
    assign o_time_last  = r_o_tl;
    assign o_slope_x    = r_o_slope[0];
    assign o_slope_y    = r_o_slope[1];
    assign o_slope_z    = r_o_slope[2];
    assign o_offset_x   = r_o_off[0];
    assign o_offset_y   = r_o_off[1];
    assign o_offset_z   = r_o_off[2];

endmodule

>>> sv/object_constant_velocity_predictor.sv
// Constant-velocity predictor: per object, every skip_period-th pose sample is kept and a
// line is fitted through the last two kept samples, giving slope and time-zero offset for
// x, y and z. A sample that is skipped or names an object number of OBJECTS or above
// gives no word. A kept sample with fewer than two samples or equal times skips the fit and
// waits for the output register to be free; a full fit runs its divisions on the one
// shared 64-bit serial divider (one quotient bit a cycle, six divisions per fit). One item
// is worked on at a time; the output register holds a finished word while the next sample
// is taken.
module object_constant_velocity_predictor #(
    parameter int OBJECTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_object_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_sample_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_object_num,
    output logic [1:0]         o_status,
    output logic [31:0]        o_time_first,
    output logic [31:0]        o_time_last,
    output logic signed [47:0] o_slope_x,
    output logic signed [47:0] o_slope_y,
    output logic signed [47:0] o_slope_z,
    output logic signed [63:0] o_offset_x,
    output logic signed [63:0] o_offset_y,
    output logic signed [63:0] o_offset_z
);

    ocvp_pkg::t_cmd  cmd;
    ocvp_pkg::t_stat stat;
    logic            in_ready;

    ocvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ocvp_dp #(.OBJECTS(OBJECTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (i_in_valid && in_ready),
        .i_object_id   (i_object_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_sample_time (i_sample_time),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_object_num  (o_object_num),
        .o_status      (o_status),
        .o_time_first  (o_time_first),
        .o_time_last   (o_time_last),
        .o_slope_x     (o_slope_x),
        .o_slope_y     (o_slope_y),
        .o_slope_z     (o_slope_z),
        .o_offset_x    (o_offset_x),
        .o_offset_y    (o_offset_y),
        .o_offset_z    (o_offset_z)
    );

    assign o_in_ready = in_ready;

endmodule

>>> sv/ocvp_checker.sv
`include "object_constant_velocity_predictor_macros.svh"

module ocvp_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [47:0] o_slope_x,
    input logic [63:0] o_offset_z
);

    `OCVP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status), "result word dropped while stalled")
    `OCVP_ASSERT_NOW(a_status_code, o_out_valid, o_status != 2'd3, "status code out of range")
    `OCVP_ASSERT_NOW(a_zero_fit, o_out_valid && o_status != 2'd0, o_slope_x == '0 && o_offset_z == '0, "fit fields set without a valid fit")
    `OCVP_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "second word taken while busy")

endmodule

bind object_constant_velocity_predictor ocvp_props u_ocvp_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_slope_x   (o_slope_x),
    .o_offset_z  (o_offset_z)
);

>>> bench/ocvp_checker.sv
`timescale 1ns / 100ps

module ocvp_checker #(
    parameter int OBJECTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_object_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_sample_time,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [2:0]         i_object_num,
    input  logic [1:0]         i_status,
    input  logic [31:0]        i_time_first,
    input  logic [31:0]        i_time_last,
    input  logic signed [47:0] i_slope_x,
    input  logic signed [47:0] i_slope_y,
    input  logic signed [47:0] i_slope_z,
    input  logic signed [63:0] i_offset_x,
    input  logic signed [63:0] i_offset_y,
    input  logic signed [63:0] i_offset_z,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] t;
    } t_pose;

    typedef struct {
        logic [2:0]         obj;
        logic [1:0]         status;
        logic [31:0]        t_first;
        logic [31:0]        t_last;
        logic signed [47:0] slope [3];
        logic signed [63:0] offset [3];
    } t_fit;

    logic [7:0] skip_period;
    logic [7:0] decim_count [OBJECTS];
    logic [1:0] kept_count [OBJECTS];
    t_pose      older_pose [OBJECTS];
    t_pose      newer_pose [OBJECTS];
    t_fit       fit_buf [DEPTH];
    logic [3:0] wr_ptr;
    logic [3:0] rd_ptr;
    int         held;

    function automatic logic signed [47:0] line_slope(logic signed [31:0] a,
                                                      logic signed [31:0] b,
                                                      longint dt);
        longint q;
        q = (longint'(b) - longint'(a)) / dt;
        if (q > 64'sd140737488355327) q = 64'sd140737488355327;
        if (q < -64'sd140737488355328) q = -64'sd140737488355328;
        return q[47:0];
    endfunction

    // exact 96-bit numerator, so the intercept never wraps before saturation
    function automatic logic signed [63:0] line_offset(logic signed [31:0] a,
                                                       logic signed [31:0] b,
                                                       logic [31:0] t1, logic [31:0] t2);
        logic signed [95:0] num, den, q;
        num = 96'(a) * $signed({64'd0, t2}) - 96'(b) * $signed({64'd0, t1});
        den = $signed({64'd0, t2}) - $signed({64'd0, t1});
        q = num / den;
        if (q > 96'sh7FFF_FFFF_FFFF_FFFF) q = 96'sh7FFF_FFFF_FFFF_FFFF;
        if (q < -96'sh8000_0000_0000_0000) q = -96'sh8000_0000_0000_0000;
        return q[63:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic take_sample();
        int    id;
        t_pose p;
        t_fit  f;
        longint dt;
        id = int'(i_object_id);
        if (id >= OBJECTS) return;
        if (decim_count[id] != 8'd255) decim_count[id] = decim_count[id] + 8'd1;
        if (decim_count[id] < skip_period) return;
        decim_count[id] = '0;
        p = '{x: i_pos_x, y: i_pos_y, z: i_pos_z, t: i_sample_time};
        older_pose[id] = newer_pose[id];
        newer_pose[id] = p;
        if (kept_count[id] < 2) kept_count[id] = kept_count[id] + 2'd1;
        f.obj = 3'(id);
        f.t_first = older_pose[id].t;
        f.t_last = p.t;
        for (int k = 0; k < 3; k++) begin
            f.slope[k] = '0;
            f.offset[k] = '0;
        end
        if (kept_count[id] < 2) begin
            f.status = ocvp_pkg::ST_FEW;
        end else if (f.t_first == f.t_last) begin
            f.status = ocvp_pkg::ST_SAME;
        end else begin
            f.status = ocvp_pkg::ST_OK;
            dt = longint'({32'd0, f.t_last}) - longint'({32'd0, f.t_first});
            f.slope[0] = line_slope(older_pose[id].x, p.x, dt);
            f.slope[1] = line_slope(older_pose[id].y, p.y, dt);
            f.slope[2] = line_slope(older_pose[id].z, p.z, dt);
            f.offset[0] = line_offset(older_pose[id].x, p.x, f.t_first, f.t_last);
            f.offset[1] = line_offset(older_pose[id].y, p.y, f.t_first, f.t_last);
            f.offset[2] = line_offset(older_pose[id].z, p.z, f.t_first, f.t_last);
        end
        if (held == DEPTH) begin
            report("prediction overflow", 64'(held), 64'(DEPTH));
            return;
        end
        fit_buf[wr_ptr] = f;
        wr_ptr = wr_ptr + 4'd1;
        held++;
    endtask

    task automatic check_word();
        t_fit f;
        if (held == 0) begin
            report("unexpected word", 64'(i_object_num), 64'd0);
            return;
        end
        f = fit_buf[rd_ptr];
        rd_ptr = rd_ptr + 4'd1;
        held--;
        if (i_object_num !== f.obj) report("object_num", 64'(i_object_num), 64'(f.obj));
        if (i_status !== f.status) report("status", 64'(i_status), 64'(f.status));
        if (i_time_first !== f.t_first) report("time_first", 64'(i_time_first), 64'(f.t_first));
        if (i_time_last !== f.t_last) report("time_last", 64'(i_time_last), 64'(f.t_last));
        if (i_slope_x !== f.slope[0]) report("slope_x", 64'(i_slope_x), 64'(f.slope[0]));
        if (i_slope_y !== f.slope[1]) report("slope_y", 64'(i_slope_y), 64'(f.slope[1]));
        if (i_slope_z !== f.slope[2]) report("slope_z", 64'(i_slope_z), 64'(f.slope[2]));
        if (i_offset_x !== f.offset[0]) report("offset_x", i_offset_x, f.offset[0]);
        if (i_offset_y !== f.offset[1]) report("offset_y", i_offset_y, f.offset[1]);
        if (i_offset_z !== f.offset[2]) report("offset_z", i_offset_z, f.offset[2]);
    endtask

    initial o_fail_count = 0;
    assign o_pending = held;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            skip_period = 8'd1;
            for (int k = 0; k < OBJECTS; k++) begin
                decim_count[k] = '0;
                kept_count[k] = '0;
                older_pose[k] = '0;
                newer_pose[k] = '0;
            end
            wr_ptr = '0;
            rd_ptr = '0;
            held = 0;
        end else begin
            if (i_cfg_wr_en) skip_period = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) check_word();
            if (i_in_valid && i_in_ready) take_sample();
        end
    end

endmodule

>>> bench/tb_object_constant_velocity_predictor.sv
`timescale 1ns / 100ps

module tb_object_constant_velocity_predictor;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_wr_en;
    logic [7:0]         cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         object_id;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [31:0]        sample_time;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         object_num;
    logic [1:0]         status;
    logic [31:0]        time_first, time_last;
    logic signed [47:0] slope_x, slope_y, slope_z;
    logic signed [63:0] offset_x, offset_y, offset_z;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;
    logic [31:0]        obj_clock [8];

    object_constant_velocity_predictor #(.OBJECTS(8)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_object_id(object_id), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_sample_time(sample_time),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_object_num(object_num), .o_status(status),
        .o_time_first(time_first), .o_time_last(time_last),
        .o_slope_x(slope_x), .o_slope_y(slope_y), .o_slope_z(slope_z),
        .o_offset_x(offset_x), .o_offset_y(offset_y), .o_offset_z(offset_z)
    );

    ocvp_checker #(.OBJECTS(8)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_object_id(object_id), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_sample_time(sample_time),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_object_num(object_num), .i_status(status),
        .i_time_first(time_first), .i_time_last(time_last),
        .i_slope_x(slope_x), .i_slope_y(slope_y), .i_slope_z(slope_z),
        .i_offset_x(offset_x), .i_offset_y(offset_y), .i_offset_z(offset_z),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, from the falling edge
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no accepted word either side
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("object_constant_velocity_predictor regression: fail");
            $finish;
        end
    end

    // valid stays up after a word is taken until the next send or an explicit idle
    task automatic send(logic [2:0] id, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        object_id <= id;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        sample_time <= t;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (500) @(negedge i_clk);
    endtask

    task automatic set_skip(logic [7:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // mostly forward-moving per-object clocks, sometimes repeated, backwards or wild
    task automatic send_random();
        logic [2:0]  id;
        logic [31:0] t;
        id = 3'($urandom_range(7));
        case ($urandom_range(9))
            0: t = obj_clock[id];
            1: t = obj_clock[id] - $urandom_range(50);
            2: t = $urandom;
            3: t = obj_clock[id] + $urandom;
            default: t = obj_clock[id] + $urandom_range(1, 100);
        endcase
        obj_clock[id] = t;
        send(id, rand_pos(), rand_pos(), rand_pos(), t);
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        object_id = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        sample_time = '0;
        out_ready = 1'b1;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 8; k++) obj_clock[k] = 32'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: first sample, equal times, extremes, backwards time, huge gap
        send(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
        send(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd0);
        send(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
        send(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'd0);
        send(3'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd7, 32'd3);
        send(3'd7, 32'h1234_5678, 32'hFEDC_BA98, 32'h8000_0001, 32'hFFFF_FFFE);
        send(3'd7, 32'h8765_4321, 32'h0123_4567, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
        send(3'd7, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'h8000_0000);
        send(3'd5, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send(3'd5, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h8000_0000);
        set_skip(8'd3);
        for (int k = 0; k < 7; k++) send(3'd2, rand_pos(), rand_pos(), rand_pos(), k * 10);

        // random phases with settings and idling varied
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin set_skip(8'd0); send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin set_skip(8'd1); send_idle_pct = 77; recv_stall_pct = 0; end
                2: begin set_skip(8'd2); send_idle_pct = 0; recv_stall_pct = 77; end
                3: begin set_skip(8'd255); send_idle_pct = 15; recv_stall_pct = 15; end
                4: begin set_skip(8'd4); send_idle_pct = 0; recv_stall_pct = 0; end
                default: begin set_skip(8'd1); send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph == 3) begin
                for (int n = 0; n < 270; n++) send(3'd1, rand_pos(), rand_pos(),
                                                   rand_pos(), $urandom_range(1000));
            end else begin
                for (int n = 0; n < 52; n++) begin
                    send_random();
                    if (n == 26) drain();
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0)
            $display("object_constant_velocity_predictor regression: pass");
        else
            $display("object_constant_velocity_predictor regression: fail");
        $finish;
    end

endmodule

>>> object_constant_velocity_predictor.f
+incdir+sv
sv/ocvp_pkg.sv
sv/ocvp_div.sv
sv/ocvp_ctrl.sv
sv/ocvp_dp.sv
sv/object_constant_velocity_predictor.sv
sv/ocvp_checker.sv
bench/ocvp_checker.sv
bench/tb_object_constant_velocity_predictor.sv
